// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker module of the moment accumulator.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define OMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Implication form of the clocked assertion.
`define OMA_ASSERT_IMP(lbl, pre, post, msg) \
  `OMA_ASSERT(lbl, (pre) |-> (post), msg)

`endif

// ----- hw/rtl/oma_pkg.sv -----
// Shared constants and saturating helpers of the online moment accumulator.
// Depends on nothing; used by the top level and its checker.
package oma_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 65536;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned MEAN_W = 48;
  localparam int unsigned COUNT_OUT_W = 17;
  localparam int unsigned STD_W = 31;
  localparam int unsigned OUT_DATA_W = 144;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SUM_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SUM_LO = -SUM_HI;
  localparam logic signed [63:0] KURT_OFFSET = 64'sd50331648;
  localparam logic signed [63:0] MEAN_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] MEAN_LO = -MEAN_HI - 64'sd1;

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > SUM_HI) begin
      return S64_MAX;
    end else if (s < SUM_LO) begin
      return -S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// ----- hw/rtl/online_moment_accumulator.sv -----
// Online moment accumulator: running count, mean and central moment sums.
// Depends on oma_pkg for widths, constants and saturating helpers.
//
// Usage: samples arrive as signed Q16.16 words on the slave stream; tlast
// marks the final sample of a set. Each transfer is folded into the count,
// mean and the sums M2, M3 and M4. After the transfer marked last, one result
// leaves on the master stream: count, mean, standard deviation, skewness and
// excess kurtosis in tdata, and the degenerate flag in tuser.
// Multiplications and divisions run through one shared 64 by 64 multiplier,
// built from four 32 by 32 partial products, followed by a bit-serial 128 by
// 64 divider (one quotient bit a cycle) and a bit-serial square root. An
// accumulated sample takes 17 multiplies, six of which also divide. A last
// sample of a nondegenerate set adds the square root and five result
// divisions. tready is low while a sample is being worked on. Once the count
// reaches MAX_SAMPLES further samples are taken but not accumulated.
// The result register lets the next set start while a result waits; if a new
// result is due before the old one is taken, the block holds until the
// receiver accepts. Reset clears all sums and drops any pending result.
module online_moment_accumulator #(
  parameter int unsigned MAX_SAMPLES = oma_pkg::MAX_SAMPLES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // sample [31:0]
  input  logic [oma_pkg::SAMPLE_W-1:0]    s_axis_tdata_i,
  input  logic                            s_axis_tlast_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // sample_count [16:0], mean_value [48:17], std_dev [79:49],
  // skewness [111:80], excess_kurtosis [143:112]
  output logic [oma_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // degenerate [0]
  output logic [0:0]                      m_axis_tuser_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_SQRT = 3'd5;
  localparam logic [2:0] ST_CHK  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam logic [4:0] SP_NN   = 5'd0;
  localparam logic [4:0] SP_DN   = 5'd1;
  localparam logic [4:0] SP_D2   = 5'd2;
  localparam logic [4:0] SP_D3   = 5'd3;
  localparam logic [4:0] SP_D4   = 5'd4;
  localparam logic [4:0] SP_T4A  = 5'd5;
  localparam logic [4:0] SP_T4   = 5'd6;
  localparam logic [4:0] SP_C4A1 = 5'd7;
  localparam logic [4:0] SP_C4A2 = 5'd8;
  localparam logic [4:0] SP_C4A3 = 5'd9;
  localparam logic [4:0] SP_C4B1 = 5'd10;
  localparam logic [4:0] SP_C4B2 = 5'd11;
  localparam logic [4:0] SP_T3A  = 5'd12;
  localparam logic [4:0] SP_T3   = 5'd13;
  localparam logic [4:0] SP_C31  = 5'd14;
  localparam logic [4:0] SP_C32  = 5'd15;
  localparam logic [4:0] SP_T2   = 5'd16;
  localparam logic [4:0] SR_SD   = 5'd17;
  localparam logic [4:0] SR_G    = 5'd18;
  localparam logic [4:0] SR_SK   = 5'd19;
  localparam logic [4:0] SR_Q1   = 5'd20;
  localparam logic [4:0] SR_K    = 5'd21;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_32 = 2'd1;
  localparam logic [1:0] SH_48 = 2'd2;

  localparam logic [6:0] MUL_LAST  = 7'd3;
  localparam logic [6:0] DIV_LAST  = 7'd127;
  localparam logic [6:0] SQRT_LAST = 7'd63;

  logic [2:0]  state_q, state_d;
  logic [4:0]  step_q, step_d;
  logic [6:0]  it_q, it_d;
  logic        last_q, last_d;
  logic [CntW-1:0] count_q, count_d, n_q, n_d;
  logic signed [oma_pkg::MEAN_W-1:0] mean_q, mean_d;
  logic signed [63:0] m2_q, m2_d, m3_q, m3_d, m4_q, m4_d;
  logic        out_valid_q, out_valid_d;
  logic [oma_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic        out_deg_q, out_deg_d;
  logic        deg_q, deg_d;

  logic signed [63:0] e_q, e_d, dn_q, dn_d, d2_q, d2_d, d3_q, d3_d;
  logic signed [63:0] w_q, w_d, nn_q, nn_d, skew_q, skew_d;
  logic [63:0]  a_mag_q, a_mag_d, b_mag_q, b_mag_d, dv_q, dv_d, root_q, root_d;
  logic         neg_q, neg_d, div_q, div_d;
  logic [1:0]   sh_q, sh_d;
  logic [127:0] acc_q, acc_d;
  logic [66:0]  rem_q, rem_d;

  logic signed [63:0] op_a, op_b;
  logic [63:0]  op_d, n64, cnt64;
  logic         op_div;
  logic [1:0]   op_sh;
  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [127:0] pp_ext, res_sel;
  logic [63:0]  umag, clamp_mag;
  logic signed [63:0] res, msum;
  logic [64:0]  div_sh, div_diff;
  logic [66:0]  sq_sh, sq_trial, sq_diff;
  logic         accept, full, out_free;
  logic [47:0]  mean_rnd, sd_wide;
  logic [30:0]  std_out;

  assign n64   = 64'(n_q);
  assign cnt64 = 64'(count_q);
  assign full  = (count_q == CntW'(MAX_SAMPLES));
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_deg_q;

  always_comb begin
    op_a = '0;
    op_b = '0;
    op_d = '0;
    op_div = 1'b0;
    op_sh = SH_0;
    case (step_q)
      SP_NN: begin
        op_a = n64; op_b = n64;
      end
      SP_DN: begin
        op_a = e_q; op_b = 64'sd1; op_div = 1'b1; op_d = n64;
      end
      SP_D2: begin
        op_a = e_q; op_b = e_q; op_sh = SH_48;
      end
      SP_D3: begin
        op_a = d2_q; op_b = e_q; op_sh = SH_32;
      end
      SP_D4: begin
        op_a = d3_q; op_b = e_q; op_sh = SH_32;
      end
      SP_T4A: begin
        op_a = w_q; op_b = n64 - 64'd1; op_div = 1'b1; op_d = n64;
      end
      SP_T4: begin
        op_a = w_q; op_b = nn_q - (n64 + (n64 << 1)) + 64'd3;
        op_div = 1'b1; op_d = nn_q;
      end
      SP_C4A1: begin
        op_a = dn_q; op_b = dn_q; op_sh = SH_32;
      end
      SP_C4A2: begin
        op_a = w_q; op_b = m2_q; op_sh = SH_32;
      end
      SP_C4A3: begin
        op_a = w_q; op_b = 64'sd6;
      end
      SP_C4B1: begin
        op_a = dn_q; op_b = m3_q; op_sh = SH_32;
      end
      SP_C4B2: begin
        op_a = w_q; op_b = 64'sd4;
      end
      SP_T3A: begin
        op_a = d3_q; op_b = n64 - 64'd1; op_div = 1'b1; op_d = n64;
      end
      SP_T3: begin
        op_a = w_q; op_b = (n64 >= 64'd2) ? n64 - 64'd2 : 64'd0;
        op_div = 1'b1; op_d = n64;
      end
      SP_C31: begin
        op_a = dn_q; op_b = m2_q; op_sh = SH_32;
      end
      SP_C32: begin
        op_a = w_q; op_b = 64'sd3;
      end
      SP_T2: begin
        op_a = d2_q; op_b = n64 - 64'd1; op_div = 1'b1; op_d = n64;
      end
      SR_SD: begin
        op_a = m2_q; op_b = 64'sh0001_0000_0000_0000; op_div = 1'b1; op_d = cnt64;
      end
      SR_G: begin
        op_a = m3_q; op_b = 64'sd16777216; op_div = 1'b1; op_d = m2_q;
      end
      SR_SK: begin
        op_a = w_q; op_b = 64'sh0000_0001_0000_0000; op_div = 1'b1; op_d = root_q;
      end
      SR_Q1: begin
        op_a = m4_q; op_b = 64'sd16777216; op_div = 1'b1; op_d = m2_q;
      end
      SR_K: begin
        op_a = w_q; op_b = cnt64 << 16; op_div = 1'b1; op_d = m2_q;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign a_part = it_q[0] ? a_mag_q[63:32] : a_mag_q[31:0];
  assign b_part = it_q[1] ? b_mag_q[63:32] : b_mag_q[31:0];
  assign pp = 64'(a_part) * 64'(b_part);

  always_comb begin
    case (it_q[1:0])
      2'd0:    pp_ext = {64'd0, pp};
      2'd3:    pp_ext = {pp, 64'd0};
      default: pp_ext = {32'd0, pp, 32'd0};
    endcase
  end

  always_comb begin
    case (sh_q)
      SH_32:   res_sel = acc_q >> 32;
      SH_48:   res_sel = acc_q >> 48;
      default: res_sel = acc_q;
    endcase
    if (div_q) begin
      res_sel = acc_q;
    end
    umag = (|res_sel[127:64]) ? '1 : res_sel[63:0];
    clamp_mag = umag[63] ? 64'(oma_pkg::S64_MAX) : umag;
    res = neg_q ? -$signed(clamp_mag) : $signed(clamp_mag);
  end

  assign div_sh   = {rem_q[63:0], acc_q[127]};
  assign div_diff = div_sh - {1'b0, dv_q};
  assign sq_sh    = {rem_q[64:0], acc_q[127:126]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_diff  = sq_sh - sq_trial;

  assign msum = oma_pkg::sadd64(64'(mean_q), dn_q);
  assign mean_rnd = mean_q[47] ? mean_q + 48'd65535 : mean_q;
  assign sd_wide = root_q[63:16];
  assign std_out = (|sd_wide[47:31]) ? '1 : sd_wide[30:0];

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    it_d = it_q;
    last_d = last_q;
    count_d = count_q;
    n_d = n_q;
    mean_d = mean_q;
    m2_d = m2_q;
    m3_d = m3_q;
    m4_d = m4_q;
    out_valid_d = out_valid_q;
    out_data_d = out_data_q;
    out_deg_d = out_deg_q;
    deg_d = deg_q;
    e_d = e_q;
    dn_d = dn_q;
    d2_d = d2_q;
    d3_d = d3_q;
    w_d = w_q;
    nn_d = nn_q;
    skew_d = skew_q;
    a_mag_d = a_mag_q;
    b_mag_d = b_mag_q;
    dv_d = dv_q;
    root_d = root_q;
    neg_d = neg_q;
    div_d = div_q;
    sh_d = sh_q;
    acc_d = acc_q;
    rem_d = rem_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_d = s_axis_tlast_i;
          e_d = {{16{s_axis_tdata_i[31]}}, s_axis_tdata_i, 16'd0}
                - 64'(mean_q);
          n_d = count_q + CntW'(1);
          step_d = SP_NN;
          if (!full) begin
            state_d = ST_LOAD;
          end else if (s_axis_tlast_i) begin
            state_d = ST_CHK;
          end
        end
      end
      ST_LOAD: begin
        a_mag_d = op_a[63] ? 64'(-op_a) : 64'(op_a);
        b_mag_d = op_b[63] ? 64'(-op_b) : 64'(op_b);
        neg_d = op_a[63] ^ op_b[63];
        div_d = op_div;
        sh_d = op_sh;
        dv_d = op_d;
        acc_d = '0;
        it_d = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        acc_d = acc_q + pp_ext;
        it_d = it_q + 7'd1;
        if (it_q == MUL_LAST) begin
          it_d = '0;
          rem_d = '0;
          state_d = div_q ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        if (!div_diff[64]) begin
          rem_d = 67'(div_diff);
        end else begin
          rem_d = 67'(div_sh);
        end
        acc_d = {acc_q[126:0], !div_diff[64]};
        it_d = it_q + 7'd1;
        if (it_q == DIV_LAST) begin
          it_d = '0;
          if (step_q == SR_SD) begin
            rem_d = '0;
            root_d = '0;
            state_d = ST_SQRT;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SQRT: begin
        if (!sq_diff[66]) begin
          rem_d = sq_diff;
          root_d = {root_q[62:0], 1'b1};
        end else begin
          rem_d = sq_sh;
          root_d = {root_q[62:0], 1'b0};
        end
        acc_d = {acc_q[125:0], 2'b00};
        it_d = it_q + 7'd1;
        if (it_q == SQRT_LAST) begin
          step_d = SR_G;
          state_d = ST_LOAD;
        end
      end
      ST_FIN: begin
        step_d = step_q + 5'd1;
        state_d = ST_LOAD;
        case (step_q)
          SP_NN: nn_d = res;
          SP_DN: dn_d = res;
          SP_D2: d2_d = res;
          SP_D3: d3_d = res;
          SP_T4, SP_C4A3: m4_d = oma_pkg::sadd64(m4_q, res);
          SP_C4B2: m4_d = oma_pkg::sadd64(m4_q, -res);
          SP_T3: m3_d = oma_pkg::sadd64(m3_q, res);
          SP_C32: m3_d = oma_pkg::sadd64(m3_q, -res);
          SP_T2: begin
            m2_d = oma_pkg::sadd64(m2_q, res);
            if (msum > oma_pkg::MEAN_HI) begin
              mean_d = oma_pkg::MEAN_HI[47:0];
            end else if (msum < oma_pkg::MEAN_LO) begin
              mean_d = oma_pkg::MEAN_LO[47:0];
            end else begin
              mean_d = msum[47:0];
            end
            count_d = n_q;
            state_d = last_q ? ST_CHK : ST_IDLE;
          end
          SR_SK: skew_d = (root_q == 64'd0) ? 64'sd0 : res;
          SR_K: begin
            w_d = oma_pkg::sadd64(res, -oma_pkg::KURT_OFFSET);
            deg_d = 1'b0;
            state_d = ST_OUT;
          end
          default: w_d = res;
        endcase
      end
      ST_CHK: begin
        if (m2_q <= 64'sd0 || count_q == '0) begin
          deg_d = 1'b1;
          state_d = ST_OUT;
        end else begin
          step_d = SR_SD;
          state_d = ST_LOAD;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_deg_d = deg_q;
          out_data_d[16:0] = cnt64[16:0];
          out_data_d[48:17] = mean_rnd[47:16];
          if (deg_q) begin
            out_data_d[143:49] = '0;
          end else begin
            out_data_d[79:49] = std_out;
            out_data_d[111:80] = oma_pkg::sat32(skew_q);
            out_data_d[143:112] = oma_pkg::sat32(w_q);
          end
          count_d = '0;
          mean_d = '0;
          m2_d = '0;
          m3_d = '0;
          m4_d = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= SP_NN;
      it_q <= '0;
      last_q <= 1'b0;
      count_q <= '0;
      mean_q <= '0;
      m2_q <= '0;
      m3_q <= '0;
      m4_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      it_q <= it_d;
      last_q <= last_d;
      count_q <= count_d;
      mean_q <= mean_d;
      m2_q <= m2_d;
      m3_q <= m3_d;
      m4_q <= m4_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    out_data_q <= out_data_d;
    out_deg_q <= out_deg_d;
    deg_q <= deg_d;
    e_q <= e_d;
    dn_q <= dn_d;
    d2_q <= d2_d;
    d3_q <= d3_d;
    w_q <= w_d;
    nn_q <= nn_d;
    skew_q <= skew_d;
    a_mag_q <= a_mag_d;
    b_mag_q <= b_mag_d;
    dv_q <= dv_d;
    root_q <= root_d;
    neg_q <= neg_d;
    div_q <= div_d;
    sh_q <= sh_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

endmodule

// ----- hw/rtl/oma_checker.sv -----
// Port-level checker of the online moment accumulator, bound to the top level.
// Depends on assert_macros.svh and oma_pkg.
`include "assert_macros.svh"

module oma_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [oma_pkg::OUT_DATA_W-1:0] out_data_i,
  input logic [0:0]                     out_user_i
);

  `OMA_ASSERT_IMP(a_out_hold, out_valid_i && !out_ready_i, ##1 out_valid_i, "result dropped while stalled")
  `OMA_ASSERT_IMP(a_out_stable, out_valid_i && !out_ready_i, ##1 $stable(out_data_i), "result changed while stalled")
  `OMA_ASSERT_IMP(a_out_after_busy, $rose(out_valid_i), $past(!in_ready_i), "result appeared without a busy cycle")
  `OMA_ASSERT_IMP(a_degenerate_zero, out_valid_i && out_user_i[0], out_data_i[143:49] == '0, "degenerate result carries nonzero statistics")

endmodule

bind online_moment_accumulator oma_checker u_oma_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (s_axis_tready_o),
  .out_valid_i(m_axis_tvalid_o),
  .out_ready_i(m_axis_tready_i),
  .out_data_i (m_axis_tdata_o),
  .out_user_i (m_axis_tuser_o)
);
